[rtl/pgt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pgt_pkg;

  // Word widths of the transcendental section (fixed by the number format)
  localparam int Y_W        = 32;  // normalized W, Q1.31
  localparam int F_W        = 32;  // log2 fraction bits, one per log cell
  localparam int Q_W        = 32;  // quotient N2/y, Q.24
  localparam int Z_W        = 32;  // root, Q.28
  localparam int T_W        = 6;   // exponent count t
  localparam int H_W        = 5;   // t / 2
  localparam int W_W        = 64;  // normalizer word
  localparam int NORM_STEPS = 6;
  localparam int LOG_CELLS  = 32;
  localparam int DIV_CELLS  = 32;
  localparam int SQRT_CELLS = 32;
  localparam int N_W        = 41;  // -2 ln W in Q.32, doubled when t is odd

  // 2 ln 2 in Q1.30
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

  // Largest |x| in Q.32 before scaling
  localparam logic [39:0] X_CAP = 40'hFF_FFFF_FFFF;

  localparam int SAMPLE_W   = 32;
  localparam int MEAN_W     = 32;
  localparam int STD_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MEAN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STD_DEV = 2'd1;

  localparam logic [STD_W-1:0] STD_DEV_RESET = 24'd65536;

  typedef enum logic [1:0] {
    BUF_EMPTY,
    BUF_FIRST,
    BUF_SECOND
  } pgt_buf_e;

endpackage

`default_nettype wire

[rtl/pgt_log_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One bit of log2 by squaring: y <- y^2, halve and emit 1 when it reaches 2.
module pgt_log_cell import pgt_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              valid_i,
  input  wire logic [SIDE_W-1:0] side_i,
  input  wire logic [Y_W-1:0]    y_i,
  input  wire logic [F_W-1:0]    f_i,
  input  wire logic [Y_W-1:0]    yn_i,
  output logic                   valid_o,
  output logic [SIDE_W-1:0]      side_o,
  output logic [Y_W-1:0]         y_o,
  output logic [F_W-1:0]         f_o,
  output logic [Y_W-1:0]         yn_o
);

  logic [2*Y_W-1:0] sq;
  logic [Y_W:0]     y2;
  logic [Y_W-1:0]   y_d;
  logic             bit_d;
  logic             valid_q;
  logic [SIDE_W-1:0] side_q;
  logic [Y_W-1:0]   y_q;
  logic [F_W-1:0]   f_q;
  logic [Y_W-1:0]   yn_q;

  always_comb begin
    sq = {{Y_W{1'b0}}, y_i} * {{Y_W{1'b0}}, y_i};
    y2 = sq[2*Y_W-1:Y_W-1];
    if (y2[Y_W]) begin
      y_d   = y2[Y_W:1];
      bit_d = 1'b1;
    end else begin
      y_d   = y2[Y_W-1:0];
      bit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q <= side_i;
      y_q    <= y_d;
      f_q    <= {f_i[F_W-2:0], bit_d};
      yn_q   <= yn_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign y_o     = y_q;
  assign f_o     = f_q;
  assign yn_o    = yn_q;

endmodule

`default_nettype wire

[rtl/pgt_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One quotient bit of a restoring divide; the partial remainder stays below y.
module pgt_div_cell import pgt_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              valid_i,
  input  wire logic [SIDE_W-1:0] side_i,
  input  wire logic [Y_W-1:0]    rem_i,
  input  wire logic [Q_W-1:0]    dl_i,
  input  wire logic [Q_W-1:0]    q_i,
  input  wire logic [Y_W-1:0]    y_i,
  output logic                   valid_o,
  output logic [SIDE_W-1:0]      side_o,
  output logic [Y_W-1:0]         rem_o,
  output logic [Q_W-1:0]         dl_o,
  output logic [Q_W-1:0]         q_o,
  output logic [Y_W-1:0]         y_o
);

  logic [Y_W:0]      rr;
  logic [Y_W:0]      diff;
  logic              qbit;
  logic [Y_W-1:0]    rem_d;
  logic              valid_q;
  logic [SIDE_W-1:0] side_q;
  logic [Y_W-1:0]    rem_q;
  logic [Q_W-1:0]    dl_q;
  logic [Q_W-1:0]    q_q;
  logic [Y_W-1:0]    y_q;

  always_comb begin
    rr    = {rem_i, dl_i[Q_W-1]};
    diff  = rr - {1'b0, y_i};
    qbit  = (rr >= {1'b0, y_i});
    rem_d = qbit ? diff[Y_W-1:0] : rr[Y_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q <= side_i;
      rem_q  <= rem_d;
      dl_q   <= {dl_i[Q_W-2:0], 1'b0};
      q_q    <= {q_i[Q_W-2:0], qbit};
      y_q    <= y_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;
  assign dl_o    = dl_q;
  assign q_o     = q_q;
  assign y_o     = y_q;

endmodule

`default_nettype wire

[rtl/pgt_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One root bit of a digit-by-digit square root; radicand bits enter two at a time.
module pgt_sqrt_cell import pgt_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              valid_i,
  input  wire logic [SIDE_W-1:0] side_i,
  input  wire logic [Q_W-1:0]    rad_i,
  input  wire logic [Z_W+1:0]    rem_i,
  input  wire logic [Z_W-1:0]    root_i,
  output logic                   valid_o,
  output logic [SIDE_W-1:0]      side_o,
  output logic [Q_W-1:0]         rad_o,
  output logic [Z_W+1:0]         rem_o,
  output logic [Z_W-1:0]         root_o
);

  logic [Z_W+3:0]    rem2;
  logic [Z_W+3:0]    trial;
  logic [Z_W+3:0]    diff;
  logic              rbit;
  logic              valid_q;
  logic [SIDE_W-1:0] side_q;
  logic [Q_W-1:0]    rad_q;
  logic [Z_W+1:0]    rem_q;
  logic [Z_W-1:0]    root_q;

  always_comb begin
    rem2  = {rem_i, rad_i[Q_W-1:Q_W-2]};
    trial = {2'b00, root_i, 2'b01};
    diff  = rem2 - trial;
    rbit  = (rem2 >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q <= side_i;
      rad_q  <= {rad_i[Q_W-3:0], 2'b00};
      rem_q  <= rbit ? diff[Z_W+1:0] : rem2[Z_W+1:0];
      root_q <= {root_i[Z_W-2:0], rbit};
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

`default_nettype wire

[rtl/pgt_scale.sv]
`timescale 1ns / 1ps
`default_nettype none

// One output lane: |u| * m, shift into Q.32 with cap, scale by std_dev, add mean, saturate.
module pgt_scale import pgt_pkg::*; #(
  parameter int UNIFORM_BITS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     adv_i,
  input  wire logic                     valid_i,
  input  wire logic [UNIFORM_BITS-1:0]  mag_i,
  input  wire logic                     neg_i,
  input  wire logic [Z_W-1:0]           z_i,
  input  wire logic [H_W-1:0]           h_i,
  input  wire logic signed [MEAN_W-1:0] mean_i,
  input  wire logic [STD_W-1:0]         std_dev_i,
  output logic                          valid_o,
  output logic [SAMPLE_W-1:0]           sample_o
);

  localparam int S_OFF  = 4 - (UNIFORM_BITS - 1);
  localparam int SC_SH  = 48 - FRAC_BITS;
  localparam logic [63:0] X_CAP64 = 64'(X_CAP);

  logic [3:0]          valid_q;
  logic [63:0]         prod_q;
  logic [H_W-1:0]      h1_q;
  logic [2:0]          neg_q;
  logic [39:0]         x_q;
  logic [63:0]         pr_q;
  logic [SAMPLE_W-1:0] sample_q;

  logic [7:0]          s_v;
  logic [5:0]          shamt;
  logic [5:0]          rshamt;
  logic [63:0]         xr;
  logic                ovf;
  logic [39:0]         x_d;
  logic [39:0]         sc;
  logic signed [41:0]  mag_s;
  logic signed [41:0]  v_s;
  logic signed [41:0]  sum;
  logic [SAMPLE_W-1:0] sample_d;

  // Shift into Q.32: left or truncating right, capped at X_CAP either way
  always_comb begin
    s_v    = 8'(h1_q) + 8'(S_OFF);
    shamt  = s_v[5:0];
    rshamt = 6'(8'd0 - s_v);
    xr     = prod_q >> rshamt;
    ovf    = 1'b0;
    if (!s_v[7]) begin
      ovf = (s_v >= 8'd40) || (prod_q > (X_CAP64 >> shamt));
      x_d = ovf ? X_CAP : 40'(prod_q << shamt);
    end else begin
      x_d = (xr > X_CAP64) ? X_CAP : xr[39:0];
    end
  end

  always_comb begin
    sc    = 40'(pr_q >> SC_SH);
    mag_s = $signed({2'b00, sc});
    v_s   = neg_q[2] ? -mag_s : mag_s;
    sum   = $signed({{(42-MEAN_W){mean_i[MEAN_W-1]}}, mean_i}) + v_s;
    if (sum > 42'sd2147483647) begin
      sample_d = 32'h7FFF_FFFF;
    end else if (sum < -42'sd2147483648) begin
      sample_d = 32'h8000_0000;
    end else begin
      sample_d = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q   <= 64'(mag_i) * 64'(z_i);
      h1_q     <= h_i;
      neg_q    <= {neg_q[1:0], neg_i};
      x_q      <= x_d;
      pr_q     <= 64'(x_q) * 64'(std_dev_i);
      sample_q <= sample_d;
    end
  end

  assign valid_o  = valid_q[3];
  assign sample_o = sample_q;

endmodule

`default_nettype wire

[rtl/polar_gaussian_transform_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// The first sample of a pair is offered once the pair leaves the pipeline, the second after the
// first is taken. Takes one request per cycle unless in_stall_o holds it back; the output carries
// one sample per cycle while not stalled, so a kept pair yields two samples and a rejected pair none.
// The chain of 32 log, 32 divide and 32 root cells makes up most of the pipeline depth.
// Reset clears all valid bits and the output buffer; mean = 0, std_dev = 1.0.
module polar_gaussian_transform_unit import pgt_pkg::*; #(
  parameter int UNIFORM_BITS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [UNIFORM_BITS-1:0] uni_a_i,
  input  wire logic [UNIFORM_BITS-1:0] uni_b_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [SAMPLE_W-1:0]          sample_o,
  output logic                         last_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int UB     = UNIFORM_BITS;
  localparam int WF     = 2 * (UB - 1);
  localparam int SIDE_W = 2 * UB + 2 + T_W;
  localparam int T_LO   = 2 * UB + 2;

  // ---------------- configuration ----------------
  logic signed [MEAN_W-1:0] mean_q;
  logic [STD_W-1:0]         std_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      std_q  <= STD_DEV_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MEAN:    mean_q <= $signed(cfg_data_i[MEAN_W-1:0]);
        CFG_STD_DEV: std_q  <= cfg_data_i[STD_W-1:0];
        default:     ;
      endcase
    end
  end

  // ---------------- output buffer control ----------------
  pgt_buf_e buf_q, buf_d;
  logic     adv;
  logic     v_end;
  logic     can_load;
  logic     out_take;
  logic [SAMPLE_W-1:0] smp_a, smp_b;
  logic [SAMPLE_W-1:0] smp_a_q, smp_b_q;
  logic     va_end, vb_end;

  assign v_end    = va_end && vb_end;
  assign out_take = out_valid_o && !out_stall_i;
  assign can_load = (buf_q == BUF_EMPTY) || ((buf_q == BUF_SECOND) && out_take);
  assign adv      = can_load || !v_end;
  assign in_stall_o = !adv;

  always_comb begin
    buf_d = buf_q;
    if (adv && v_end) begin
      buf_d = BUF_FIRST;
    end else begin
      case (buf_q)
        BUF_FIRST:  if (out_take) buf_d = BUF_SECOND;
        BUF_SECOND: if (out_take) buf_d = BUF_EMPTY;
        default:    buf_d = buf_q;
      endcase
    end
  end

  always_comb begin
    case (buf_q)
      BUF_FIRST: begin
        out_valid_o = 1'b1;
        sample_o    = smp_a_q;
        last_o      = 1'b0;
      end
      BUF_SECOND: begin
        out_valid_o = 1'b1;
        sample_o    = smp_b_q;
        last_o      = 1'b1;
      end
      default: begin
        out_valid_o = 1'b0;
        sample_o    = smp_a_q;
        last_o      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= BUF_EMPTY;
    end else begin
      buf_q <= buf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v_end) begin
      smp_a_q <= smp_a;
      smp_b_q <= smp_b;
    end
  end

  // ---------------- front: magnitudes, squares, W, reject ----------------
  logic [UB-1:0]     mag_a, mag_b;
  logic              f0_v_q, f1_v_q;
  logic [SIDE_W-1:0] f0_side_q, f1_side_q;
  logic [2*UB-1:0]   sqa_q, sqb_q;
  logic [2*UB:0]     wsum;
  logic              w_ok;

  assign mag_a = uni_a_i[UB-1] ? (~uni_a_i + 1'b1) : uni_a_i;
  assign mag_b = uni_b_i[UB-1] ? (~uni_b_i + 1'b1) : uni_b_i;
  assign wsum  = {1'b0, sqa_q} + {1'b0, sqb_q};
  // drop pairs with W == 0 or W >= 1
  assign w_ok  = (wsum != '0) && ((wsum >> WF) == '0);

  logic              nv_q   [NORM_STEPS+1];
  logic [W_W-1:0]    nw_q   [NORM_STEPS+1];
  logic [T_W-1:0]    nlz_q  [NORM_STEPS+1];
  logic [SIDE_W-1:0] nside_q[NORM_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_v_q   <= 1'b0;
      f1_v_q   <= 1'b0;
      nv_q[0]  <= 1'b0;
    end else if (adv) begin
      f0_v_q   <= in_valid_i;
      f1_v_q   <= f0_v_q;
      nv_q[0]  <= f1_v_q && w_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f0_side_q  <= {{T_W{1'b0}}, uni_b_i[UB-1], uni_a_i[UB-1], mag_b, mag_a};
      f1_side_q  <= f0_side_q;
      sqa_q      <= {{UB{1'b0}}, f0_side_q[UB-1:0]} * {{UB{1'b0}}, f0_side_q[UB-1:0]};
      sqb_q      <= {{UB{1'b0}}, f0_side_q[2*UB-1:UB]} *
                    {{UB{1'b0}}, f0_side_q[2*UB-1:UB]};
      nw_q[0]    <= W_W'(wsum);
      nlz_q[0]   <= '0;
      nside_q[0] <= f1_side_q;
    end
  end

  // Normalize: shift left by 32, 16, ... 1 while the top bits are zero
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int AMT = 32 >> k;
    logic zero_top;
    assign zero_top = (nw_q[k][W_W-1 -: AMT] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[k+1] <= 1'b0;
      end else if (adv) begin
        nv_q[k+1] <= nv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        nw_q[k+1]    <= zero_top ? (nw_q[k] << AMT) : nw_q[k];
        nlz_q[k+1]   <= zero_top ? (nlz_q[k] | T_W'(AMT)) : nlz_q[k];
        nside_q[k+1] <= nside_q[k];
      end
    end
  end

  logic [T_W-1:0] t_v;
  assign t_v = nlz_q[NORM_STEPS] - T_W'(63 - WF);

  // ---------------- log2 chain ----------------
  logic              lg_v   [LOG_CELLS+1];
  logic [SIDE_W-1:0] lg_side[LOG_CELLS+1];
  logic [Y_W-1:0]    lg_y   [LOG_CELLS+1];
  logic [F_W-1:0]    lg_f   [LOG_CELLS+1];
  logic [Y_W-1:0]    lg_yn  [LOG_CELLS+1];

  assign lg_v[0]    = nv_q[NORM_STEPS];
  assign lg_side[0] = {t_v, nside_q[NORM_STEPS][T_LO-1:0]};
  assign lg_y[0]    = nw_q[NORM_STEPS][W_W-1 -: Y_W];
  assign lg_f[0]    = '0;
  assign lg_yn[0]   = nw_q[NORM_STEPS][W_W-1 -: Y_W];

  for (genvar i = 0; i < LOG_CELLS; i++) begin : g_log
    pgt_log_cell #(.SIDE_W(SIDE_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (lg_v[i]),
      .side_i  (lg_side[i]),
      .y_i     (lg_y[i]),
      .f_i     (lg_f[i]),
      .yn_i    (lg_yn[i]),
      .valid_o (lg_v[i+1]),
      .side_o  (lg_side[i+1]),
      .y_o     (lg_y[i+1]),
      .f_o     (lg_f[i+1]),
      .yn_o    (lg_yn[i+1])
    );
  end

  // ---------------- -2 ln W and dividend ----------------
  logic [T_W+31:0]   l_v;
  logic              m1_v_q, m2_v_q;
  logic [SIDE_W-1:0] m1_side_q, m2_side_q;
  logic [Y_W-1:0]    m1_y_q, m2_y_q;
  logic [T_W+30:0]   pa_q;
  logic [62:0]       pb_q;
  logic [N_W-1:0]    n_v;
  logic [N_W-1:0]    n2_v;
  logic [63:0]       dvd;
  logic [Y_W-1:0]    m2_rem_q;
  logic [Q_W-1:0]    m2_dl_q;

  assign l_v  = {lg_side[LOG_CELLS][SIDE_W-1 -: T_W], 32'b0} -
                {{T_W{1'b0}}, lg_f[LOG_CELLS]};
  assign n_v  = N_W'({pa_q, 2'b00}) + N_W'(pb_q >> 30);
  assign n2_v = m1_side_q[T_LO] ? (n_v << 1) : n_v;
  assign dvd  = {n2_v[39:0], 24'b0} >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
    end else if (adv) begin
      m1_v_q <= lg_v[LOG_CELLS];
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_side_q <= lg_side[LOG_CELLS];
      m1_y_q    <= lg_yn[LOG_CELLS];
      pa_q      <= (T_W+31)'(l_v[T_W+31:32]) * (T_W+31)'(TWO_LN2_Q30);
      pb_q      <= 63'(l_v[31:0]) * 63'(TWO_LN2_Q30);
      m2_side_q <= m1_side_q;
      m2_y_q    <= m1_y_q;
      m2_rem_q  <= dvd[63:32];
      m2_dl_q   <= dvd[31:0];
    end
  end

  // ---------------- divide chain ----------------
  logic              dv_v   [DIV_CELLS+1];
  logic [SIDE_W-1:0] dv_side[DIV_CELLS+1];
  logic [Y_W-1:0]    dv_rem [DIV_CELLS+1];
  logic [Q_W-1:0]    dv_dl  [DIV_CELLS+1];
  logic [Q_W-1:0]    dv_q   [DIV_CELLS+1];
  logic [Y_W-1:0]    dv_y   [DIV_CELLS+1];

  assign dv_v[0]    = m2_v_q;
  assign dv_side[0] = m2_side_q;
  assign dv_rem[0]  = m2_rem_q;
  assign dv_dl[0]   = m2_dl_q;
  assign dv_q[0]    = '0;
  assign dv_y[0]    = m2_y_q;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    pgt_div_cell #(.SIDE_W(SIDE_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dv_v[i]),
      .side_i  (dv_side[i]),
      .rem_i   (dv_rem[i]),
      .dl_i    (dv_dl[i]),
      .q_i     (dv_q[i]),
      .y_i     (dv_y[i]),
      .valid_o (dv_v[i+1]),
      .side_o  (dv_side[i+1]),
      .rem_o   (dv_rem[i+1]),
      .dl_o    (dv_dl[i+1]),
      .q_o     (dv_q[i+1]),
      .y_o     (dv_y[i+1])
    );
  end

  // ---------------- square root chain ----------------
  logic              sq_v   [SQRT_CELLS+1];
  logic [SIDE_W-1:0] sq_side[SQRT_CELLS+1];
  logic [Q_W-1:0]    sq_rad [SQRT_CELLS+1];
  logic [Z_W+1:0]    sq_rem [SQRT_CELLS+1];
  logic [Z_W-1:0]    sq_root[SQRT_CELLS+1];

  assign sq_v[0]    = dv_v[DIV_CELLS];
  assign sq_side[0] = dv_side[DIV_CELLS];
  assign sq_rad[0]  = dv_q[DIV_CELLS];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    pgt_sqrt_cell #(.SIDE_W(SIDE_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (sq_v[i]),
      .side_i  (sq_side[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .valid_o (sq_v[i+1]),
      .side_o  (sq_side[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1])
    );
  end

  // ---------------- output lanes ----------------
  logic [SIDE_W-1:0] fin_side;
  logic [H_W-1:0]    fin_h;

  assign fin_side = sq_side[SQRT_CELLS];
  assign fin_h    = fin_side[SIDE_W-1 -: H_W];

  pgt_scale #(.UNIFORM_BITS(UB), .FRAC_BITS(FRAC_BITS)) u_lane_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (sq_v[SQRT_CELLS]),
    .mag_i     (fin_side[UB-1:0]),
    .neg_i     (fin_side[2*UB]),
    .z_i       (sq_root[SQRT_CELLS]),
    .h_i       (fin_h),
    .mean_i    (mean_q),
    .std_dev_i (std_q),
    .valid_o   (va_end),
    .sample_o  (smp_a)
  );

  pgt_scale #(.UNIFORM_BITS(UB), .FRAC_BITS(FRAC_BITS)) u_lane_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (sq_v[SQRT_CELLS]),
    .mag_i     (fin_side[2*UB-1:UB]),
    .neg_i     (fin_side[2*UB+1]),
    .z_i       (sq_root[SQRT_CELLS]),
    .h_i       (fin_h),
    .mean_i    (mean_q),
    .std_dev_i (std_q),
    .valid_o   (vb_end),
    .sample_o  (smp_b)
  );

  // ---------------- assertions ----------------
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && last_o)
    else $error("second sample of a pair did not follow the first");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v_end && out_valid_o)
    else $error("input stalled with no finished pair waiting");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_q == BUF_EMPTY) |-> !in_stall_o)
    else $error("input stalled while output buffer is empty");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_end == vb_end)
    else $error("output lanes out of step");

endmodule

`default_nettype wire

[verif/pgt_sample_checker.sv]
`timescale 1ns / 1ps

module pgt_sample_checker import pgt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire logic [15:0]           uni_a_i,
  input  wire logic [15:0]           uni_b_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire logic [SAMPLE_W-1:0]   sample_i,
  input  wire logic                  last_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         samples_owed_o,
  output int                         pairs_taken_o,
  output int                         pairs_dropped_o,
  output int                         samples_seen_o
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } gauss_sample_t;

  localparam longint unsigned CAP40 = (64'd1 << 40) - 64'd1;

  gauss_sample_t owed_q[$];
  logic signed [MEAN_W-1:0] mean_r;
  logic [STD_W-1:0]         std_r;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v = v - (r + bit_w);
        r = (r >> 1) + bit_w;
      end else begin
        r = r >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] scale_sample(longint unsigned mag, logic neg,
                                                       longint unsigned z, int sh);
    longint unsigned prod;
    longint unsigned x;
    longint unsigned scaled;
    longint          sum;
    prod = mag * z;
    if (sh >= 0) begin
      if (sh >= 40 || prod > (CAP40 >> sh)) x = CAP40;
      else x = prod << sh;
    end else begin
      x = prod >> (-sh);
    end
    if (x > CAP40) x = CAP40;
    scaled = (x * longint'(std_r)) >> (48 - 16);
    sum = longint'(mean_r) + (neg ? -longint'(scaled) : longint'(scaled));
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[SAMPLE_W-1:0];
  endfunction

  // Push the pair of samples a candidate request yields, if it is kept.
  function automatic void predict_pair(logic [15:0] a, logic [15:0] b);
    longint unsigned ma, mb, w, y, y0, f, l, n, n2, qv, z;
    logic na, nb;
    int p, t, e, sh;
    gauss_sample_t s;
    na = a[15];
    nb = b[15];
    ma = na ? (64'd65536 - a) : a;
    mb = nb ? (64'd65536 - b) : b;
    w = ma * ma + mb * mb;
    if (w == 0 || w >= (64'd1 << 30)) begin
      pairs_dropped_o++;
      return;
    end
    p = 63;
    while (w[p] == 1'b0) p--;
    t = 30 - p;
    y0 = (p >= 31) ? (w >> (p - 31)) : (w << (31 - p));
    y = y0;
    f = 0;
    for (int i = 31; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y >= (64'd1 << 32)) begin
        y = y >> 1;
        f = f | (64'd1 << i);
      end
    end
    l = (longint'(t) << 32) - f;
    n = (((l >> 32) * TWO_LN2_Q30) << 2) + (((l & 64'hFFFF_FFFF) * TWO_LN2_Q30) >> 30);
    if (t % 2 == 1) begin
      n2 = n << 1;
      e = t - 1;
    end else begin
      n2 = n;
      e = t;
    end
    qv = (n2 << 23) / y0;
    z = int_sqrt(qv << 32);
    sh = e / 2 + 4 - 15;
    s.sample = scale_sample(ma, na, z, sh);
    s.last = 1'b0;
    owed_q.push_back(s);
    s.sample = scale_sample(mb, nb, z, sh);
    s.last = 1'b1;
    owed_q.push_back(s);
    pairs_taken_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gauss_sample_t want;
    if (!rst_ni) begin
      mean_r <= '0;
      std_r <= STD_DEV_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MEAN: begin
            mean_r <= cfg_data_i;
          end
          CFG_STD_DEV: begin
            std_r <= cfg_data_i[STD_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_pair(uni_a_i, uni_b_i);
      if (out_valid_i && !out_stall_i) begin
        samples_seen_o++;
        if (owed_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected sample %h last %b", $realtime, sample_i, last_i);
        end else begin
          want = owed_q.pop_front();
          if (want.sample !== sample_i || want.last !== last_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: sample mismatch: expected %h last %b, got %h last %b",
                       $realtime, want.sample, want.last, sample_i, last_i);
          end
        end
      end
    end
    samples_owed_o = owed_q.size();
  end

  initial begin
    fail_count_o = 0;
    samples_owed_o = 0;
    pairs_taken_o = 0;
    pairs_dropped_o = 0;
    samples_seen_o = 0;
  end

endmodule

[verif/tb_polar_gaussian_transform_unit.sv]
`timescale 1ns / 1ps

module tb_polar_gaussian_transform_unit;
  import pgt_pkg::*;

  localparam int LIMIT = 400000;
  localparam int SETTLE = 130;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [15:0] uni_a_i = '0;
  logic [15:0] uni_b_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_MEAN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic long_hold_go = 1'b0;
  logic in_stall_o, out_valid_o, last_o, cfg_ready_o;
  logic [SAMPLE_W-1:0] sample_o;
  int fail_count, samples_owed, pairs_taken, pairs_dropped, samples_seen;
  int cycle_count = 0;

  polar_gaussian_transform_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .uni_a_i, .uni_b_i,
    .out_valid_o, .out_stall_i, .sample_o, .last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  pgt_sample_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .uni_a_i, .uni_b_i,
    .out_valid_i(out_valid_o), .out_stall_i, .sample_i(sample_o), .last_i(last_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .samples_owed_o(samples_owed),
    .pairs_taken_o(pairs_taken), .pairs_dropped_o(pairs_dropped),
    .samples_seen_o(samples_seen)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb_polar_gaussian_transform_unit failed");
      $finish;
    end
  end

  // Receiver: random stall modes, plus one long hold-off when asked.
  initial begin
    int mode, span;
    forever begin
      if (long_hold_go) begin
        repeat (400) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
        @(posedge clk_i);
        out_stall_i <= 1'b0;
        wait (!long_hold_go);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
        if (long_hold_go) break;
      end
    end
  end

  // Call at a rising edge; leaves the request on the bus after acceptance.
  task automatic send_pair(logic [15:0] a, logic [15:0] b);
    in_valid_i <= 1'b1;
    uni_a_i <= a;
    uni_b_i <= b;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (samples_owed != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_burst(int count);
    int burst;
    int kind;
    logic [15:0] a, b;
    burst = 0;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // Stay inside the unit circle so most pairs are kept.
        a = 16'($urandom_range(0, 46340) - 23170);
        b = 16'($urandom_range(0, 46340) - 23170);
      end else if (kind < 8) begin
        a = 16'($urandom);
        b = 16'($urandom);
      end else begin
        a = 16'($urandom_range(0, 15) - 8);
        b = (kind == 8) ? 16'($urandom) : 16'($urandom_range(0, 3));
      end
      if (burst == 0) begin
        idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
        burst = $urandom_range(1, 40);
      end
      send_pair(a, b);
      burst--;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners with reset configuration.
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h8000, 16'h0000);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h0001, 16'h0000);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'h7FFF, 16'h0000);
    send_pair(16'h0000, 16'h8001);
    send_pair(16'd23170, 16'd23170);
    send_pair(16'd23171, 16'd23171);
    send_pair(16'h5A82, 16'hA57E);
    send_pair(16'h0003, 16'hFFFD);
    send_pair(16'h4000, 16'hC000);
    send_pair(16'h00FF, 16'h0100);
    send_pair(16'hAAAA, 16'h5555);
    drain();

    write_reg(CFG_MEAN, 32'h7FFF_FFFF);
    write_reg(CFG_STD_DEV, 32'h00FF_FFFF);
    send_pair(16'h0001, 16'h0000);
    send_pair(16'h0001, 16'hFFFF);
    send_pair(16'h6000, 16'hA000);
    random_burst(60);
    drain();

    write_reg(CFG_MEAN, 32'h8000_0000);
    write_reg(CFG_STD_DEV, 32'd0);
    send_pair(16'h1234, 16'hEDCC);
    random_burst(40);
    drain();
    write_reg(CFG_MEAN, 32'h8000_0000);

    write_reg(CFG_STD_DEV, 32'h00FF_FFFF);
    send_pair(16'h0001, 16'h0000);
    send_pair(16'hFFFF, 16'h0000);
    drain();

    write_reg(CFG_MEAN, $urandom);
    write_reg(CFG_STD_DEV, $urandom_range(1, 24'hFF_FFFF));
    long_hold_go <= 1'b1;
    random_burst(200);
    long_hold_go <= 1'b0;
    drain();

    write_reg(CFG_MEAN, 32'd0);
    write_reg(CFG_STD_DEV, 32'(STD_DEV_RESET));
    random_burst(200);
    drain();

    $display("covered %0d kept and %0d rejected pairs, %0d samples checked",
             pairs_taken, pairs_dropped, samples_seen);
    $display("mean and std_dev swept across extremes, long output hold-off included");
    if (fail_count == 0 && samples_owed == 0) begin
      $display("tb_polar_gaussian_transform_unit passed");
    end else begin
      $display("tb_polar_gaussian_transform_unit failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pgt_pkg.sv
rtl/pgt_log_cell.sv
rtl/pgt_div_cell.sv
rtl/pgt_sqrt_cell.sv
rtl/pgt_scale.sv
rtl/polar_gaussian_transform_unit.sv
verif/pgt_sample_checker.sv
verif/tb_polar_gaussian_transform_unit.sv
